>>> rtl/ibbs_pkg.sv
// shared types and constants for the infrared beam-break sequencer
package ibbs_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned TickW  = 8;
  localparam int unsigned StateW = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // failure count saturation point
  localparam logic [CountW-1:0] FailSat = 7'd100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBreakThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldOffReload  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRestoreMode    = 2'd2;

  typedef struct packed {
    logic timer_tick;
    logic rx0_level;
    logic rx1_level;
    logic rx2_level;
    logic slow_tick;
  } item_t;

  typedef struct packed {
    logic              emitter0_on;
    logic              emitter1_on;
    logic              broken_event;
    logic              restore_event;
    logic              beep_start;
    logic              show_count;
    logic [CountW-1:0] shown_value;
    logic [CountW-1:0] failure_count;
  } result_t;

endpackage

>>> rtl/ir_beam_break_sequencer.sv
// infrared beam-break sequencer: input register, one-pass state update, result register
// an item is held in the input register, then its result is held in the result register
// throughput: one item per cycle while the result register is not stalled; the only feedback is the state update
// stalls: the input register holds while the result register waits for its transfer
// reset (rst, synchronous, active high): state 0, ticks 0, failure count 100,
//   hold-off 0, threshold 1, reload 0, restore mode off, both stages empty
module ir_beam_break_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  ibbs_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output ibbs_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ibbs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ibbs_pkg::CfgDataW-1:0]     cfg_data
);

  // sequence state codes
  localparam logic [ibbs_pkg::StateW-1:0] StWaitP0   = 4'd0;
  localparam logic [ibbs_pkg::StateW-1:0] StEndP0    = 4'd1;
  localparam logic [ibbs_pkg::StateW-1:0] StPause0   = 4'd2;
  localparam logic [ibbs_pkg::StateW-1:0] StEmit0    = 4'd3;
  localparam logic [ibbs_pkg::StateW-1:0] StGap0     = 4'd4;
  localparam logic [ibbs_pkg::StateW-1:0] StWaitP1   = 4'd5;
  localparam logic [ibbs_pkg::StateW-1:0] StEndP1    = 4'd6;
  localparam logic [ibbs_pkg::StateW-1:0] StPause1   = 4'd7;
  localparam logic [ibbs_pkg::StateW-1:0] StEmit1    = 4'd8;
  localparam logic [ibbs_pkg::StateW-1:0] StGap1     = 4'd9;
  localparam logic [ibbs_pkg::StateW-1:0] StWaitP2   = 4'd10;
  localparam logic [ibbs_pkg::StateW-1:0] StEndP2    = 4'd11;
  localparam logic [ibbs_pkg::StateW-1:0] StSettle   = 4'd12;
  localparam logic [ibbs_pkg::StateW-1:0] StError    = 4'd13;

  // tick limits
  localparam logic [ibbs_pkg::TickW-1:0] TimeoutP0 = 8'd85;
  localparam logic [ibbs_pkg::TickW-1:0] TimeoutPx = 8'd130;
  localparam logic [ibbs_pkg::TickW-1:0] PauseLen  = 8'd24;
  localparam logic [ibbs_pkg::TickW-1:0] EmitLen   = 8'd20;
  localparam logic [ibbs_pkg::TickW-1:0] GapLen    = 8'd64;
  localparam logic [ibbs_pkg::TickW-1:0] SettleLen = 8'd18;
  localparam logic [ibbs_pkg::HoldW-1:0] RestoreHold = 16'd100;

  // configuration registers
  logic [ibbs_pkg::CountW-1:0] break_threshold;
  logic [ibbs_pkg::HoldW-1:0]  hold_off_reload;
  logic                        restore_mode;

  // sequencer state
  logic [ibbs_pkg::StateW-1:0] seq_state, seq_state_next;
  logic [ibbs_pkg::TickW-1:0]  tick_count, tick_count_next;
  logic [ibbs_pkg::CountW-1:0] fail_count, fail_count_next;
  logic [ibbs_pkg::HoldW-1:0]  hold_off, hold_off_next;

  // pipeline stages
  logic               s1_valid;
  ibbs_pkg::item_t    s1_item;
  ibbs_pkg::result_t  result_next;
  logic               advance;

  // the input register moves on whenever the result register is free or drains
  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_threshold <= 7'd1;
      hold_off_reload <= '0;
      restore_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ibbs_pkg::CfgBreakThreshold: break_threshold <= cfg_data[ibbs_pkg::CountW-1:0];
        ibbs_pkg::CfgHoldOffReload:  hold_off_reload <= cfg_data;
        ibbs_pkg::CfgRestoreMode:    restore_mode    <= cfg_data[0];
        default: ;  // no register at this index
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // one pass of the sequencer for the item in the input register
  always_comb begin
    logic                        pulse0, pulse1, pulse2;
    logic                        broken, restore, show;
    logic [ibbs_pkg::CountW-1:0] shown;
    logic [ibbs_pkg::TickW-1:0]  ticks;

    pulse0  = !s1_item.rx0_level;
    pulse1  = !s1_item.rx1_level;
    pulse2  = !s1_item.rx2_level;
    broken  = 1'b0;
    restore = 1'b0;
    show    = 1'b0;
    shown   = '0;

    // the tick advances before the state is evaluated
    ticks = s1_item.timer_tick ? tick_count + 8'd1 : tick_count;

    seq_state_next  = seq_state;
    tick_count_next = ticks;
    fail_count_next = fail_count;
    hold_off_next   = hold_off;

    unique case (seq_state)
      StWaitP0: begin
        // timeout wins over a pulse seen in the same item
        if (ticks >= TimeoutP0) seq_state_next = StError;
        else if (pulse0)        seq_state_next = StEndP0;
      end
      StEndP0: begin
        if (!pulse0) begin
          seq_state_next  = StPause0;
          tick_count_next = '0;
        end
      end
      StPause0: begin
        if (ticks >= PauseLen) begin
          seq_state_next  = StEmit0;
          tick_count_next = '0;
        end
      end
      StEmit0: begin
        if (ticks >= EmitLen) seq_state_next = StGap0;
      end
      StGap0: begin
        // ticks keep running from the emitter phase
        if (ticks >= GapLen) seq_state_next = StWaitP1;
      end
      StWaitP1: begin
        if (ticks >= TimeoutPx) seq_state_next = StError;
        else if (pulse1)        seq_state_next = StEndP1;
      end
      StEndP1: begin
        if (!pulse1) begin
          seq_state_next  = StPause1;
          tick_count_next = '0;
        end
      end
      StPause1: begin
        if (ticks >= PauseLen) begin
          seq_state_next  = StEmit1;
          tick_count_next = '0;
        end
      end
      StEmit1: begin
        if (ticks >= EmitLen) begin
          seq_state_next  = StGap1;
          tick_count_next = '0;
        end
      end
      StGap1: begin
        if (ticks >= GapLen) seq_state_next = StWaitP2;
      end
      StWaitP2: begin
        // a pulse clears the count even when the timeout hits in the same item
        if (pulse2) begin
          seq_state_next = StEndP2;
          if (restore_mode && fail_count != '0) begin
            hold_off_next = RestoreHold;
            restore       = 1'b1;
          end
          fail_count_next = '0;
        end
        if (ticks >= TimeoutPx) seq_state_next = StError;
      end
      StEndP2: begin
        if (!pulse2) begin
          seq_state_next  = StSettle;
          tick_count_next = '0;
        end
      end
      StSettle: begin
        if (ticks >= SettleLen) seq_state_next = StWaitP0;
      end
      StError: begin
        if (fail_count < ibbs_pkg::FailSat) begin
          if (restore_mode && hold_off == '0) begin
            show  = 1'b1;
            shown = fail_count;
          end
          fail_count_next = fail_count + 7'd1;
        end
        tick_count_next = '0;
        seq_state_next  = StWaitP0;
      end
      default: begin
        seq_state_next = StWaitP0;
      end
    endcase

    // broken event on the updated count, hold-off gates repeats
    if (fail_count_next == break_threshold && hold_off_next == '0) begin
      fail_count_next = fail_count_next + 7'd1;
      hold_off_next   = hold_off_reload;
      broken          = 1'b1;
    end

    // hold-off counts down after the event check
    if (s1_item.slow_tick && hold_off_next != '0) begin
      hold_off_next = hold_off_next - 16'd1;
    end

    result_next.emitter0_on   = (seq_state_next == StEmit0);
    result_next.emitter1_on   = (seq_state_next == StEmit1);
    result_next.broken_event  = broken;
    result_next.restore_event = restore;
    result_next.beep_start    = broken || restore;
    result_next.show_count    = show;
    result_next.shown_value   = shown;
    result_next.failure_count = fail_count_next;
  end

  // state commits when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state  <= StWaitP0;
      tick_count <= '0;
      fail_count <= ibbs_pkg::FailSat;
      hold_off   <= '0;
    end else if (s1_valid && advance) begin
      seq_state  <= seq_state_next;
      tick_count <= tick_count_next;
      fail_count <= fail_count_next;
      hold_off   <= hold_off_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/ibbs_checker.sv
// port-level checks for the beam-break sequencer, bound to the top level
module ibbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input ibbs_pkg::result_t result
);

  // a stalled result keeps its transfer pending and unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // the two emitters are never driven together
  a_emitters_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.emitter0_on && result.emitter1_on))
    else $error("both emitters on");

  // a beep starts exactly on a broken or restore event
  a_beep_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.beep_start == (result.broken_event || result.restore_event))
    else $error("beep without matching event");

  // shown value is zero unless displayed, and below saturation when displayed
  a_shown_value: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.show_count ? result.shown_value < ibbs_pkg::FailSat
                                        : result.shown_value == '0))
    else $error("bad shown value");

  // restore clears the count, so it never comes with a nonzero count unless broken
  a_restore_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.restore_event && !result.broken_event
      |-> result.failure_count == '0)
    else $error("restore left a nonzero count");

endmodule

bind ir_beam_break_sequencer ibbs_checker u_ibbs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
